// ----- hdl/bridge_window_mapper_top_assert.svh -----
// Assertion macros used by the bridge window mapper port-level checker.
`ifndef BRIDGE_WINDOW_MAPPER_TOP_ASSERT_SVH
`define BRIDGE_WINDOW_MAPPER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bridge window mapper check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define BWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bridge window mapper check failed");

`endif

// ----- hdl/bwm_pkg.sv -----
// Shared types and constants of the bridge window mapper.
`default_nettype none

package bwm_pkg;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  map_number;
    logic        active;
    logic        width_16;
    logic        zero_wait;
    logic [31:0] window_start;
    logic [31:0] window_stop;
    logic [25:0] card_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  area;
    logic [31:0] pci_base_value;
    logic [31:0] range_value;
    logic [31:0] local_base_value;
    logic        bus_width_16;
    logic        one_wait_state;
    logic [2:0]  status;
    logic        last;
  } res_t;

  // result kinds
  localparam logic [1:0] KIND_DISABLED   = 2'd0;
  localparam logic [1:0] KIND_PROGRAMMED = 2'd1;
  localparam logic [1:0] KIND_STATUS     = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TOO_LONG    = 3'd1;
  localparam logic [2:0] ST_BAD_SPLIT   = 3'd2;
  localparam logic [2:0] ST_NO_AREA     = 3'd3;
  localparam logic [2:0] ST_BELOW_MEG   = 3'd4;
  localparam logic [2:0] ST_NOT_ALIGNED = 3'd5;

  localparam logic [5:0]  TAG_USED       = 6'h20;
  localparam logic [5:0]  TAG_FREE       = 6'h00;
  localparam logic [31:0] IO_MIN         = 32'h0000_0004;
  localparam logic [31:0] CARD_MEM_BASE  = 32'h0300_0000;
  localparam logic [31:0] MEM_RANGE_MASK = 32'h0fff_fff0;
  localparam logic [31:0] IO_RANGE_MASK  = 32'h0fff_fffc;
  localparam logic [31:0] LOW_MEG        = 32'h0010_0000;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       free_step;
    logic       calc;
    logic       p_step;
    logic       split_pt;
    logic       split_a;
    logic       split_b;
    logic       claim_step;
    logic       swap;
    logic       emit_status;
    logic [2:0] status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_last;
    logic area_free;
    logic is_io;
    logic active;
    logic too_long;
    logic below_meg;
    logic aligned;
    logic p_done;
    logic split_ok;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/bridge_window_mapper_top.sv -----
// Bridge window mapper: maps I/O and memory windows onto local areas.
//
// Usage: raise start with a request on req_i while busy is low; the request
// is taken at that clock edge and busy rises on the next cycle. The block
// then produces a run of results on res_o, each valid for one cycle while
// res_valid_o is high: one "disabled" transfer per area freed, up to two
// "programmed" transfers, and a final status transfer with last set. busy
// is low again in the cycle that shows the status transfer, so a new
// request may start there.
// Per request the block scans the area table to free the areas of its tag,
// then, if the request is active and the window passes its checks, scans for
// a free area to claim, and ends with the status; an unaligned I/O window adds
// a split-point search, the split steps and a second claim. The area table is
// scanned one entry per cycle through a single index. One request is handled
// at a time.
// Reset: area 0 is reserved, all other areas are free, no result pending.
// The receiver cannot stall: every result transfer is taken as shown.
`default_nettype none

module bridge_window_mapper_top #(
  parameter int AREAS          = 4,
  parameter int IO_WINDOW_MAX  = 4096,
  parameter int MEM_WINDOW_MAX = 524288
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire bwm_pkg::req_t req_i,
  output logic               busy,
  output bwm_pkg::res_t      res_o,
  output logic               res_valid_o
);
  import bwm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bwm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  bwm_dp #(
    .AREAS          (AREAS),
    .IO_WINDOW_MAX  (IO_WINDOW_MAX),
    .MEM_WINDOW_MAX (MEM_WINDOW_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

`default_nettype wire

// ----- hdl/bwm_dp.sv -----
// Datapath: request registers, area table, window arithmetic, result register.
`default_nettype none

module bwm_dp #(
  parameter int AREAS          = 4,
  parameter int IO_WINDOW_MAX  = 4096,
  parameter int MEM_WINDOW_MAX = 524288
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bwm_pkg::req_t     req_i,
  input  wire bwm_pkg::dp_cmd_t  cmd_i,
  output bwm_pkg::dp_stat_t      stat_o,
  output bwm_pkg::res_t          res_o,
  output logic                   res_valid_o
);
  import bwm_pkg::*;

  localparam int IW = (AREAS > 2) ? $clog2(AREAS) : 1;
  localparam int PW = $clog2(IO_WINDOW_MAX + 1) + 1;
  localparam logic [31:0] IoMax  = 32'(IO_WINDOW_MAX);
  localparam logic [31:0] MemMax = 32'(MEM_WINDOW_MAX);
  localparam logic [IW-1:0] IdxFirst = IW'(1);
  localparam logic [IW-1:0] IdxLast  = IW'(AREAS - 1);

  function automatic logic is_aligned(logic [31:0] base, logic [31:0] len,
                                      logic [31:0] lm1);
    is_aligned = (len != 32'd0) && ((len & lm1) == 32'd0) && ((base & lm1) == 32'd0);
  endfunction

  req_t          req_q;
  logic [5:0]    tbl_q [AREAS];
  logic [IW-1:0] idx_q;
  logic [31:0]   base_q, len_q, lm1_q;
  logic [31:0]   sec_base_q, sec_len_q, sec_lm1_q;
  logic [31:0]   split_q;
  logic [PW-1:0] p_q;
  logic          oka_q;
  res_t          res_q, res_d;
  logic          res_valid_q;

  logic          is_io;
  logic [5:0]    tag;
  logic [5:0]    entry;
  logic [31:0]   x;
  logic [31:0]   p32;
  logic          p_done;
  logic          cur_al;
  logic          sec_al;
  logic          hit_tag;
  logic          hit_free;
  logic          idx_last;
  logic          emit;

  assign is_io    = !req_q.opcode;
  assign tag      = {1'b1, is_io, req_q.map_number};
  assign entry    = tbl_q[idx_q];
  assign x        = req_q.window_start ^ req_q.window_stop;
  assign p32      = 32'(p_q);
  assign p_done   = !((p32 <= IoMax) && (p32 <= x));
  assign cur_al   = is_aligned(base_q, len_q, lm1_q);
  assign sec_al   = is_aligned(sec_base_q, sec_len_q, sec_lm1_q);
  assign hit_tag  = (entry == tag);
  assign hit_free = (entry == TAG_FREE);
  assign idx_last = (idx_q == IdxLast);
  assign emit     = cmd_i.emit_status || (cmd_i.free_step && hit_tag) ||
                    (cmd_i.claim_step && hit_free);

  always_comb begin
    stat_o.idx_last  = idx_last;
    stat_o.area_free = hit_free;
    stat_o.is_io     = is_io;
    stat_o.active    = req_q.active;
    stat_o.too_long  = is_io ? (len_q > IoMax) : (len_q > MemMax);
    stat_o.below_meg = (req_q.window_start < LOW_MEG);
    stat_o.aligned   = cur_al;
    stat_o.p_done    = p_done;
    stat_o.split_ok  = oka_q && sec_al;
  end

  always_comb begin
    res_d = '0;
    if (cmd_i.emit_status) begin
      res_d.kind   = KIND_STATUS;
      res_d.status = cmd_i.status;
      res_d.last   = 1'b1;
    end else if (cmd_i.free_step) begin
      res_d.kind = KIND_DISABLED;
      res_d.area = 2'(idx_q);
    end else begin
      res_d.kind           = KIND_PROGRAMMED;
      res_d.area           = 2'(idx_q);
      res_d.pci_base_value = base_q | {31'd0, is_io};
      res_d.range_value    = is_io ? ((~lm1_q & IO_RANGE_MASK) | 32'd1)
                                   : (~lm1_q & MEM_RANGE_MASK);
      res_d.local_base_value = is_io ? 32'd1
          : ({6'd0, req_q.card_offset} | CARD_MEM_BASE | 32'd1);
      res_d.bus_width_16   = req_q.width_16;
      res_d.one_wait_state = !req_q.zero_wait;
    end
  end

  // control state: table, scan index, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AREAS; i++) begin
        tbl_q[i] <= (i == 0) ? TAG_USED : TAG_FREE;
      end
      idx_q       <= IdxFirst;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= emit;
      if (cmd_i.load || cmd_i.calc || cmd_i.swap) begin
        idx_q <= IdxFirst;
      end else if (cmd_i.free_step) begin
        if (hit_tag) tbl_q[idx_q] <= TAG_FREE;
        if (!idx_last) idx_q <= idx_q + IW'(1);
      end else if (cmd_i.claim_step) begin
        if (hit_free) begin
          tbl_q[idx_q] <= tag;
        end else if (!idx_last) begin
          idx_q <= idx_q + IW'(1);
        end
      end
    end
  end

  // window arithmetic
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.calc) begin
      base_q <= req_q.window_start;
      len_q  <= req_q.window_stop - req_q.window_start + 32'd1;
      lm1_q  <= req_q.window_stop - req_q.window_start;
      p_q    <= PW'(IO_MIN);
    end
    if (cmd_i.p_step && !p_done) p_q <= p_q << 1;
    if (cmd_i.split_pt) begin
      split_q <= (req_q.window_start & ~(p32 - 32'd1)) + (p32 >> 1);
    end
    if (cmd_i.split_a) begin
      base_q <= req_q.window_start;
      len_q  <= split_q - req_q.window_start;
      lm1_q  <= split_q - req_q.window_start - 32'd1;
    end
    if (cmd_i.split_b) begin
      oka_q      <= cur_al;
      sec_base_q <= split_q;
      sec_len_q  <= req_q.window_stop - split_q + 32'd1;
      sec_lm1_q  <= req_q.window_stop - split_q;
    end
    if (cmd_i.swap) begin
      base_q <= sec_base_q;
      len_q  <= sec_len_q;
      lm1_q  <= sec_lm1_q;
    end
    if (emit) res_q <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

`default_nettype wire

// ----- hdl/bwm_ctrl.sv -----
// Controller: sequences free scan, checks, split search and area claims.
`default_nettype none

module bwm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire bwm_pkg::dp_stat_t stat_i,
  output bwm_pkg::dp_cmd_t       cmd_o,
  output logic                   busy_o
);
  import bwm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FREE, S_CALC, S_CLASSIFY, S_PSCAN, S_SPLIT_PT, S_SPLIT_A,
    S_SPLIT_B, S_SPLIT_CHK, S_CLAIM, S_SWAP, S_DONE
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] st_q, st_d;
  logic       second_q, second_d;
  logic       busy_q, busy_d;

  always_comb begin
    state_d  = state_q;
    st_d     = st_q;
    second_d = second_q;
    busy_d   = busy_q;
    cmd_o    = '0;
    cmd_o.status = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && !busy_q) begin
          cmd_o.load = 1'b1;
          busy_d     = 1'b1;
          st_d       = ST_OK;
          second_d   = 1'b0;
          state_d    = S_FREE;
        end
      end
      S_FREE: begin
        cmd_o.free_step = 1'b1;
        if (stat_i.idx_last) state_d = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = stat_i.active ? S_CLASSIFY : S_DONE;
      end
      S_CLASSIFY: begin
        if (stat_i.is_io) begin
          priority if (stat_i.too_long) begin
            st_d    = ST_TOO_LONG;
            state_d = S_DONE;
          end else if (stat_i.aligned) begin
            state_d = S_CLAIM;
          end else begin
            state_d = S_PSCAN;
          end
        end else begin
          priority if (stat_i.below_meg) begin
            st_d    = ST_BELOW_MEG;
            state_d = S_DONE;
          end else if (stat_i.too_long) begin
            st_d    = ST_TOO_LONG;
            state_d = S_DONE;
          end else if (!stat_i.aligned) begin
            st_d    = ST_NOT_ALIGNED;
            state_d = S_DONE;
          end else begin
            state_d = S_CLAIM;
          end
        end
      end
      S_PSCAN: begin
        cmd_o.p_step = 1'b1;
        if (stat_i.p_done) state_d = S_SPLIT_PT;
      end
      S_SPLIT_PT: begin
        cmd_o.split_pt = 1'b1;
        state_d        = S_SPLIT_A;
      end
      S_SPLIT_A: begin
        cmd_o.split_a = 1'b1;
        state_d       = S_SPLIT_B;
      end
      S_SPLIT_B: begin
        cmd_o.split_b = 1'b1;
        state_d       = S_SPLIT_CHK;
      end
      S_SPLIT_CHK: begin
        if (stat_i.split_ok) begin
          second_d = 1'b1;
          state_d  = S_CLAIM;
        end else begin
          st_d    = ST_BAD_SPLIT;
          state_d = S_DONE;
        end
      end
      S_CLAIM: begin
        cmd_o.claim_step = 1'b1;
        if (stat_i.area_free) begin
          second_d = 1'b0;
          state_d  = second_q ? S_SWAP : S_DONE;
        end else if (stat_i.idx_last) begin
          st_d    = ST_NO_AREA;
          state_d = S_DONE;
        end
      end
      S_SWAP: begin
        cmd_o.swap = 1'b1;
        state_d    = S_CLAIM;
      end
      S_DONE: begin
        cmd_o.emit_status = 1'b1;
        busy_d            = 1'b0;
        state_d           = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      st_q     <= ST_OK;
      second_q <= 1'b0;
      busy_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      st_q     <= st_d;
      second_q <= second_d;
      busy_q   <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

// ----- hdl/bwm_checker.sv -----
// Port-level checker for the bridge window mapper, bound to the top level.
`default_nettype none

`include "bridge_window_mapper_top_assert.svh"

module bwm_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start_i,
  input wire logic          busy_i,
  input wire bwm_pkg::res_t res_i,
  input wire logic          res_valid_i
);
  import bwm_pkg::*;

  `BWM_ASSERT_NEXT(a_accept_busy, start_i && !busy_i, busy_i)
  `BWM_ASSERT_NOW(a_last_is_status, res_valid_i, res_i.last == (res_i.kind == KIND_STATUS))
  `BWM_ASSERT_NOW(a_mid_run_busy, res_valid_i && !res_i.last, busy_i)
  `BWM_ASSERT_NOW(a_status_ends_run, res_valid_i && res_i.last, !busy_i)
  `BWM_ASSERT_NOW(a_fall_has_status, $fell(busy_i), res_valid_i && res_i.last)

endmodule

bind bridge_window_mapper_top bwm_checker u_bwm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start),
  .busy_i      (busy),
  .res_i       (res_o),
  .res_valid_i (res_valid_o)
);

`default_nettype wire

// ----- sim/bwm_checker.sv -----
// Checker for the bridge window mapper: predicts area reports and compares them.
`timescale 1ns / 1ps

package bwm_tb_pkg;
  localparam logic OP_IO  = 1'b0;
  localparam logic OP_MEM = 1'b1;
endpackage

module bwm_tb_checker
  import bwm_pkg::*;
  import bwm_tb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  busy_i,
  input  req_t  req_i,
  input  res_t  res_i,
  input  logic  res_valid_i,
  output int    fail_count_o,
  output int    pending_o,
  output int    checked_o
);

  localparam int AREAS          = 4;
  localparam int IO_WINDOW_MAX  = 4096;
  localparam int MEM_WINDOW_MAX = 524288;
  localparam logic [5:0] TAG_IO = 6'h10;

  logic [5:0] area_tag [AREAS];
  res_t       reports_due [$];
  int         fails;
  int         checked;
  int         due_count;

  assign fail_count_o = fails;
  assign pending_o    = due_count;
  assign checked_o    = checked;

  function automatic bit size_aligned(logic [31:0] base, logic [31:0] len);
    return (len != 32'd0) && ((len & (len - 32'd1)) == 32'd0) &&
           ((base & (len - 32'd1)) == 32'd0);
  endfunction

  task automatic push_report(input logic [1:0] kind, input logic [1:0] area,
                             input logic [31:0] pci, input logic [31:0] rng,
                             input logic [31:0] loc, input logic w16,
                             input logic ws1, input logic [2:0] st,
                             input logic last);
    res_t r;
    r.kind             = kind;
    r.area             = area;
    r.pci_base_value   = pci;
    r.range_value      = rng;
    r.local_base_value = loc;
    r.bus_width_16     = w16;
    r.one_wait_state   = ws1;
    r.status           = st;
    r.last             = last;
    reports_due.push_back(r);
  endtask

  // takes the lowest free area, if any
  task automatic claim_area(input bit io, input logic [5:0] tag,
                            input logic [31:0] base, input logic [31:0] len,
                            input logic [31:0] card, input logic w16,
                            input logic zw, output bit ok);
    logic [31:0] rng;
    ok  = 1'b0;
    rng = ~(len - 32'd1);
    rng = io ? ((rng & IO_RANGE_MASK) | 32'd1) : (rng & MEM_RANGE_MASK);
    for (int i = 1; i < AREAS; i++) begin
      if (!ok && area_tag[i] == TAG_FREE) begin
        area_tag[i] = tag;
        push_report(KIND_PROGRAMMED, i[1:0], base | {31'd0, io}, rng, card | 32'd1,
                    w16, ~zw, ST_OK, 1'b0);
        ok = 1'b1;
      end
    end
  endtask

  task automatic predict_window(input req_t r);
    bit          io;
    bit          ok;
    logic [5:0]  tag;
    logic [31:0] len;
    logic [31:0] diff;
    logic [31:0] span;
    logic [31:0] split;
    logic [2:0]  st;
    io  = (r.opcode == OP_IO);
    tag = TAG_USED | {2'b00, r.map_number} | (io ? TAG_IO : TAG_FREE);
    len = r.window_stop + 32'd1 - r.window_start;
    st  = ST_OK;
    for (int i = 1; i < AREAS; i++) begin
      if (area_tag[i] == tag) begin
        area_tag[i] = TAG_FREE;
        push_report(KIND_DISABLED, i[1:0], '0, '0, '0, 1'b0, 1'b0, ST_OK, 1'b0);
      end
    end
    if (r.active) begin
      if (io) begin
        if (len > 32'(IO_WINDOW_MAX)) begin
          st = ST_TOO_LONG;
        end else if (size_aligned(r.window_start, len)) begin
          claim_area(1'b1, tag, r.window_start, len, '0, r.width_16, r.zero_wait, ok);
          if (!ok) st = ST_NO_AREA;
        end else begin
          // smallest power of two above the differing bits sets the split
          diff = r.window_stop ^ r.window_start;
          span = IO_MIN;
          while (span <= 32'(IO_WINDOW_MAX) && span <= diff) span = span << 1;
          split = (r.window_start & ~(span - 32'd1)) + (span >> 1);
          if (!size_aligned(r.window_start, split - r.window_start) ||
              !size_aligned(split, r.window_stop + 32'd1 - split)) begin
            st = ST_BAD_SPLIT;
          end else begin
            claim_area(1'b1, tag, r.window_start, split - r.window_start, '0,
                       r.width_16, r.zero_wait, ok);
            if (ok)
              claim_area(1'b1, tag, split, r.window_stop + 32'd1 - split, '0,
                         r.width_16, r.zero_wait, ok);
            if (!ok) st = ST_NO_AREA;
          end
        end
      end else begin
        if (r.window_start < LOW_MEG) begin
          st = ST_BELOW_MEG;
        end else if (len > 32'(MEM_WINDOW_MAX)) begin
          st = ST_TOO_LONG;
        end else if (!size_aligned(r.window_start, len)) begin
          st = ST_NOT_ALIGNED;
        end else begin
          claim_area(1'b0, tag, r.window_start, len,
                     {6'd0, r.card_offset} | CARD_MEM_BASE, r.width_16, r.zero_wait, ok);
          if (!ok) st = ST_NO_AREA;
        end
      end
    end
    push_report(KIND_STATUS, 2'd0, '0, '0, '0, 1'b0, 1'b0, st, 1'b1);
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      reports_due.delete();
      area_tag[0] = TAG_USED;
      for (int i = 1; i < AREAS; i++) area_tag[i] = TAG_FREE;
      fails     = 0;
      checked   = 0;
      due_count = 0;
    end else begin
      // the status of the previous request may show in the cycle a new one starts
      if (res_valid_i === 1'b1) begin
        if (reports_due.size() == 0) begin
          $error("result transfer with nothing expected: 0x%0h", res_i);
          fails++;
        end else begin
          want = reports_due.pop_front();
          compare_field("kind", 32'(want.kind), 32'(res_i.kind));
          compare_field("area", 32'(want.area), 32'(res_i.area));
          compare_field("pci_base_value", want.pci_base_value, res_i.pci_base_value);
          compare_field("range_value", want.range_value, res_i.range_value);
          compare_field("local_base_value", want.local_base_value,
                        res_i.local_base_value);
          compare_field("bus_width_16", 32'(want.bus_width_16),
                        32'(res_i.bus_width_16));
          compare_field("one_wait_state", 32'(want.one_wait_state),
                        32'(res_i.one_wait_state));
          compare_field("status", 32'(want.status), 32'(res_i.status));
          compare_field("last", 32'(want.last), 32'(res_i.last));
          checked++;
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) predict_window(req_i);
      due_count = reports_due.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Stimulus and verdict for the bridge window mapper, with the checker beside it.
`timescale 1ns / 1ps

module testbench;
  import bwm_pkg::*;
  import bwm_tb_pkg::*;

  localparam int RANDOM_ITEMS = 100;
  localparam int CALM_ITEMS   = 20;
  localparam int TAIL_CYCLES  = 40;
  localparam int LIMIT_CYCLES = 200000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  res_t res;
  logic res_valid;
  int   fail_count;
  int   pending;
  int   checked;
  int   sent   = 0;
  int   cycles = 0;

  always #5 clk = ~clk;

  bridge_window_mapper_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .req_i       (req),
    .busy        (busy),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  bwm_tb_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .res_i        (res),
    .res_valid_i  (res_valid),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("** bridge_window_mapper_top: FAILED **");
      $finish;
    end
  end

  function automatic req_t window(input logic op, input logic [3:0] map,
                                  input int act, input int w16, input int zw,
                                  input logic [31:0] lo, input logic [31:0] hi,
                                  input logic [25:0] card);
    req_t r;
    r.opcode       = op;
    r.map_number   = map;
    r.active       = 1'(act);
    r.width_16     = 1'(w16);
    r.zero_wait    = 1'(zw);
    r.window_start = lo;
    r.window_stop  = hi;
    r.card_offset  = card;
    return r;
  endfunction

  // mostly well-formed windows on a few map numbers so areas get freed and reused
  function automatic req_t random_request();
    req_t        r;
    logic [31:0] sz;
    logic [31:0] base;
    int          k;
    int          kb;
    int          sel;
    r.opcode       = 1'($urandom_range(0, 1));
    r.map_number   = ($urandom_range(0, 3) == 0) ? 4'($urandom)
                                                 : 4'($urandom_range(0, 3));
    r.active       = ($urandom_range(0, 6) != 0);
    r.width_16     = 1'($urandom_range(0, 1));
    r.zero_wait    = 1'($urandom_range(0, 1));
    r.card_offset  = 26'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      r.window_start = $urandom;
      case (sel)
        0:       r.window_stop = $urandom;
        1:       r.window_stop = r.window_start + $urandom_range(0, 5000);
        default: r.window_stop = r.window_start - $urandom_range(0, 16);
      endcase
    end else if (r.opcode == OP_IO && sel < 6) begin
      // two adjacent aligned halves around a split point
      k    = $urandom_range(2, 11);
      kb   = $urandom_range(2, 11);
      base = $urandom & ~((32'd1 << ((k > kb) ? k : kb)) - 32'd1);
      r.window_start = base - (32'd1 << k);
      r.window_stop  = base + (32'd1 << kb) - 32'd1;
    end else begin
      k    = (r.opcode == OP_IO) ? $urandom_range(2, 12) : $urandom_range(4, 19);
      sz   = 32'd1 << k;
      base = $urandom & ~(sz - 32'd1);
      if (r.opcode == OP_MEM && base < LOW_MEG) base = base | LOW_MEG;
      r.window_start = base;
      r.window_stop  = base + sz - 32'd1;
    end
    return r;
  endfunction

  function automatic int idle_gap();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  task automatic send(input req_t r, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sent++;
  endtask

  // hold off new requests until every outstanding result has been seen
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    int directed;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send(window(OP_IO, 4'd1, 1, 1, 0, 32'h100, 32'h1ff, '0), idle_gap());
    send(window(OP_MEM, 4'd2, 1, 0, 1, 32'h0020_0000, 32'h0027_ffff, 26'h3ff_ffff),
         idle_gap());
    // split I/O window where only one area is left
    send(window(OP_IO, 4'd3, 1, 1, 1, 32'h300, 32'h4ff, '0), idle_gap());
    send(window(OP_MEM, 4'd4, 1, 1, 0, 32'h0010_0000, 32'h0010_ffff, '0), idle_gap());
    send(window(OP_IO, 4'd3, 0, 0, 0, 32'h0, 32'h0, '0), idle_gap());
    send(window(OP_IO, 4'd1, 0, 1, 1, 32'hffff_ffff, 32'hffff_ffff, 26'h3ff_ffff),
         idle_gap());
    send(window(OP_MEM, 4'd2, 1, 1, 1, 32'hffff_f000, 32'hffff_ffff, 26'h155_5555),
         idle_gap());
    send(window(OP_IO, 4'd0, 1, 0, 0, 32'h0, 32'h1000, '0), idle_gap());
    send(window(OP_IO, 4'd15, 1, 1, 0, 32'h1000, 32'h1fff, '0), idle_gap());
    send(window(OP_IO, 4'd5, 1, 0, 1, 32'h1, 32'h4, '0), idle_gap());
    // zero length, then wrapped length
    send(window(OP_IO, 4'd5, 1, 0, 0, 32'h5, 32'h4, '0), idle_gap());
    send(window(OP_IO, 4'd5, 1, 1, 1, 32'h100, 32'h0, '0), idle_gap());
    // no power of two up to the I/O limit covers the differing bits
    send(window(OP_IO, 4'd6, 1, 1, 0, 32'hffff_fffc, 32'h3, '0), idle_gap());
    send(window(OP_MEM, 4'd7, 1, 0, 0, 32'h000f_ffff, 32'h0017_fffe, '0), idle_gap());
    send(window(OP_MEM, 4'd7, 1, 0, 1, 32'h0010_0000, 32'h0018_0000, '0), idle_gap());
    send(window(OP_MEM, 4'd7, 1, 1, 0, 32'h0014_0000, 32'h001b_ffff, 26'h2aa_aaaa),
         idle_gap());
    send(window(OP_IO, 4'd15, 0, 0, 0, 32'h0, 32'h0, '0), idle_gap());
    send(window(OP_IO, 4'd0, 1, 1, 1, 32'h10, 32'h3f, '0), idle_gap());
    send(window(OP_MEM, 4'd2, 0, 0, 0, 32'h0, 32'h0, '0), idle_gap());
    send(window(OP_IO, 4'd0, 1, 0, 0, 32'hffff_fffc, 32'hffff_ffff, '0), idle_gap());
    send(window(OP_IO, 4'd0, 0, 0, 0, 32'h0, 32'h0, '0), idle_gap());
    directed = sent;
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send(random_request(), (i < RANDOM_ITEMS - CALM_ITEMS) ? idle_gap() : 0);
      if (i == RANDOM_ITEMS / 2) drain();
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d directed and %0d random window requests (I/O, memory, splits, frees).",
             directed, sent - directed);
    $display("Checked %0d result transfers, %0d mismatches.", checked, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("** bridge_window_mapper_top: PASSED **");
    else
      $display("** bridge_window_mapper_top: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/bwm_pkg.sv
hdl/bwm_dp.sv
hdl/bwm_ctrl.sv
hdl/bridge_window_mapper_top.sv
hdl/bwm_checker.sv
sim/bwm_checker.sv
sim/testbench.sv
